// File: src/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB pixel converter.
// No dependencies; every other file in src uses it by scoped names.
`default_nettype none

package hsv2rgb_pkg;

   // field widths
   localparam int HUE_W   = 13;
   localparam int COLOR_W = 8;
   localparam int FRAC_W  = 10;          // fraction numerator, 0..960
   localparam int PROD_W  = 18;          // fn*s and 244800 - fn*s
   localparam int NP_W    = 2 * COLOR_W; // v*(255-s)
   localparam int NUM_W   = COLOR_W + PROD_W;
   localparam int QUOT_W  = COLOR_W + 1;

   // hue is Q9.4 degrees: 60 degrees per sector is 960 raw
   localparam int HUE_MAX     = 5760;
   localparam int SECTOR_SPAN = 960;
   localparam int UNIT        = 255;
   localparam int QT_DEN      = 244800; // UNIT * SECTOR_SPAN

   // x / 244800 = (x >> 6) / 3825; the latter by reciprocal multiply,
   // M = ceil(2^32 / 3825), exact while (x >> 6) * 2804 < 2^32
   localparam int DEN_SHIFT   = 6;
   localparam int RED_W       = NUM_W - DEN_SHIFT;
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 21;
   localparam logic [RECIP_W-1:0] RECIP_M = 21'd1122868;
   localparam int RPROD_W     = RED_W + RECIP_W;

   typedef enum logic [2:0] {
      SEC_R_Y = 3'd0,
      SEC_Y_G = 3'd1,
      SEC_G_C = 3'd2,
      SEC_C_B = 3'd3,
      SEC_B_M = 3'd4,
      SEC_M_R = 3'd5
   } sector_type;

   // per-stage load enables, one per register stage
   typedef struct packed {
      logic s5;
      logic s4;
      logic s3;
      logic s2;
      logic s1;
   } pipe_ld_type;

endpackage

`default_nettype wire

// File: src/hsv2rgb_sector.sv
// Stage 1: hue clamp, sector decode and fraction numerator.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_sector (
   input  wire logic                              clock,
   input  wire logic                              ld,
   input  wire logic [hsv2rgb_pkg::HUE_W-1:0]     hue,
   input  wire logic [hsv2rgb_pkg::COLOR_W-1:0]   saturation,
   input  wire logic [hsv2rgb_pkg::COLOR_W-1:0]   brightness,
   output hsv2rgb_pkg::sector_type                sec_ff,
   output logic [hsv2rgb_pkg::FRAC_W-1:0]         fn_ff,
   output logic [hsv2rgb_pkg::COLOR_W-1:0]        sat_ff,
   output logic [hsv2rgb_pkg::COLOR_W-1:0]        bri_ff
);

   localparam int HW = hsv2rgb_pkg::HUE_W;
   localparam int SP = hsv2rgb_pkg::SECTOR_SPAN;

   logic [HW-1:0]                      hue_c;
   logic [HW-1:0]                      base;
   hsv2rgb_pkg::sector_type            sec_in;
   logic [hsv2rgb_pkg::FRAC_W-1:0]     fn_in;

   always_comb begin
      // anything past 360 degrees behaves as 360
      hue_c = (hue > HW'(hsv2rgb_pkg::HUE_MAX)) ? HW'(hsv2rgb_pkg::HUE_MAX) : hue;
      // 360 lands in the last sector with a full fraction
      if (hue_c >= HW'(5 * SP)) begin
         sec_in = hsv2rgb_pkg::SEC_M_R;
         base   = HW'(5 * SP);
      end else if (hue_c >= HW'(4 * SP)) begin
         sec_in = hsv2rgb_pkg::SEC_B_M;
         base   = HW'(4 * SP);
      end else if (hue_c >= HW'(3 * SP)) begin
         sec_in = hsv2rgb_pkg::SEC_C_B;
         base   = HW'(3 * SP);
      end else if (hue_c >= HW'(2 * SP)) begin
         sec_in = hsv2rgb_pkg::SEC_G_C;
         base   = HW'(2 * SP);
      end else if (hue_c >= HW'(SP)) begin
         sec_in = hsv2rgb_pkg::SEC_Y_G;
         base   = HW'(SP);
      end else begin
         sec_in = hsv2rgb_pkg::SEC_R_Y;
         base   = '0;
      end
      fn_in = hsv2rgb_pkg::FRAC_W'(hue_c - base);
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         sec_ff <= sec_in;
         fn_ff  <= fn_in;
         sat_ff <= saturation;
         bri_ff <= brightness;
      end
   end

endmodule

`default_nettype wire

// File: src/hsv2rgb_mult.sv
// Stages 2 and 3: the p/q/t numerators, then v times the q and t terms
// and the exact divide by 255 for p. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_mult (
   input  wire logic                              clock,
   input  wire hsv2rgb_pkg::pipe_ld_type          ld,
   input  wire hsv2rgb_pkg::sector_type           sec,
   input  wire logic [hsv2rgb_pkg::FRAC_W-1:0]    fn,
   input  wire logic [hsv2rgb_pkg::COLOR_W-1:0]   sat,
   input  wire logic [hsv2rgb_pkg::COLOR_W-1:0]   bri,
   output hsv2rgb_pkg::sector_type                sec3_ff,
   output logic [hsv2rgb_pkg::COLOR_W-1:0]        bri3_ff,
   output logic [hsv2rgb_pkg::COLOR_W-1:0]        cp3_ff,
   output logic [hsv2rgb_pkg::NUM_W-1:0]          nq3_ff,
   output logic [hsv2rgb_pkg::NUM_W-1:0]          nt3_ff
);

   localparam int CW = hsv2rgb_pkg::COLOR_W;
   localparam int FW = hsv2rgb_pkg::FRAC_W;
   localparam int PW = hsv2rgb_pkg::PROD_W;
   localparam int NPW = hsv2rgb_pkg::NP_W;
   localparam int NW = hsv2rgb_pkg::NUM_W;

   // stage 2
   hsv2rgb_pkg::sector_type   sec2_ff;
   logic [CW-1:0]             bri2_ff;
   logic [PW-1:0]             aq2_ff, aq2_in;
   logic [PW-1:0]             at2_ff, at2_in;
   logic [NPW-1:0]            np2_ff, np2_in;
   logic [FW-1:0]             fn_rev;

   // stage 3
   logic [CW-1:0]             cp3_in;
   logic [NW-1:0]             nq3_in, nt3_in;
   logic [NPW:0]              p_sum;

   always_comb begin
      fn_rev = FW'(hsv2rgb_pkg::SECTOR_SPAN) - fn;
      aq2_in = PW'(hsv2rgb_pkg::QT_DEN) - PW'(fn) * PW'(sat);
      at2_in = PW'(hsv2rgb_pkg::QT_DEN) - PW'(fn_rev) * PW'(sat);
      np2_in = NPW'(bri) * NPW'(CW'(hsv2rgb_pkg::UNIT) - sat);
   end

   always_ff @(posedge clock) begin
      if (ld.s2) begin
         sec2_ff <= sec;
         bri2_ff <= bri;
         aq2_ff  <= aq2_in;
         at2_ff  <= at2_in;
         np2_ff  <= np2_in;
      end
   end

   always_comb begin
      nq3_in = NW'(bri2_ff) * NW'(aq2_ff);
      nt3_in = NW'(bri2_ff) * NW'(at2_ff);
      // floor(x/255) = (x + (x>>8) + 1) >> 8, exact over 0..255*255
      p_sum  = (NPW+1)'(np2_ff) + (NPW+1)'(np2_ff >> CW) + (NPW+1)'(1);
      cp3_in = p_sum[CW +: CW];
   end

   always_ff @(posedge clock) begin
      if (ld.s3) begin
         sec3_ff <= sec2_ff;
         bri3_ff <= bri2_ff;
         cp3_ff  <= cp3_in;
         nq3_ff  <= nq3_in;
         nt3_ff  <= nt3_in;
      end
   end

endmodule

`default_nettype wire

// File: src/hsv2rgb_div.sv
// Stage 4: divide the q and t numerators by 244800 through a shift and
// a reciprocal multiply. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_div (
   input  wire logic                              clock,
   input  wire logic                              ld,
   input  wire hsv2rgb_pkg::sector_type           sec,
   input  wire logic [hsv2rgb_pkg::COLOR_W-1:0]   bri,
   input  wire logic [hsv2rgb_pkg::COLOR_W-1:0]   cp,
   input  wire logic [hsv2rgb_pkg::NUM_W-1:0]     nq,
   input  wire logic [hsv2rgb_pkg::NUM_W-1:0]     nt,
   output hsv2rgb_pkg::sector_type                sec_ff,
   output logic [hsv2rgb_pkg::COLOR_W-1:0]        bri_ff,
   output logic [hsv2rgb_pkg::COLOR_W-1:0]        cp_ff,
   output logic [hsv2rgb_pkg::QUOT_W-1:0]         cq_ff,
   output logic [hsv2rgb_pkg::QUOT_W-1:0]         ct_ff
);

   localparam int RW  = hsv2rgb_pkg::RED_W;
   localparam int RPW = hsv2rgb_pkg::RPROD_W;
   localparam int QW  = hsv2rgb_pkg::QUOT_W;
   localparam int SH  = hsv2rgb_pkg::RECIP_SHIFT;

   logic [RW-1:0]   xq, xt;
   logic [RPW-1:0]  pq, pt;
   logic [QW-1:0]   cq_in, ct_in;

   always_comb begin
      xq    = RW'(nq >> hsv2rgb_pkg::DEN_SHIFT);
      xt    = RW'(nt >> hsv2rgb_pkg::DEN_SHIFT);
      pq    = RPW'(xq) * RPW'(hsv2rgb_pkg::RECIP_M);
      pt    = RPW'(xt) * RPW'(hsv2rgb_pkg::RECIP_M);
      cq_in = pq[SH +: QW];
      ct_in = pt[SH +: QW];
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         sec_ff <= sec;
         bri_ff <= bri;
         cp_ff  <= cp;
         cq_ff  <= cq_in;
         ct_ff  <= ct_in;
      end
   end

endmodule

`default_nettype wire

// File: src/hsv_to_rgb_converter_top.sv
// Top level of the HSV to RGB pixel converter: stall control, valid chain
// and the output stage. Depends on hsv2rgb_pkg, hsv2rgb_sector,
// hsv2rgb_mult and hsv2rgb_div.
//
//   channel | ports                                 | direction
//   --------+---------------------------------------+----------
//   req     | req_valid/ready, hue, sat, brightness | in
//   rsp     | rsp_valid/ready, red, green, blue     | out
//
// Five register stages: sector decode, p/q/t numerators, products and
// divide by 255, reciprocal divide by 244800, channel select. One beat
// per clock while rsp_ready is high; rsp_valid rises as it enters stage 5.
// Each stage loads when it is empty or the stage after it moves, so a
// stall fills bubbles first and nothing is dropped or repeated.
// Reset clears the valid chain only.
`default_nettype none

module hsv_to_rgb_converter_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [hsv2rgb_pkg::HUE_W-1:0]     req_hue,
   input  wire logic [hsv2rgb_pkg::COLOR_W-1:0]   req_saturation,
   input  wire logic [hsv2rgb_pkg::COLOR_W-1:0]   req_brightness,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [hsv2rgb_pkg::COLOR_W-1:0]        rsp_red,
   output logic [hsv2rgb_pkg::COLOR_W-1:0]        rsp_green,
   output logic [hsv2rgb_pkg::COLOR_W-1:0]        rsp_blue
);

   localparam int NS = 5;
   localparam int CW = hsv2rgb_pkg::COLOR_W;
   localparam int FW = hsv2rgb_pkg::FRAC_W;
   localparam int NW = hsv2rgb_pkg::NUM_W;
   localparam int QW = hsv2rgb_pkg::QUOT_W;

   logic [NS-1:0]              vld_ff, vld_in;
   logic [NS:0]                rdy;
   hsv2rgb_pkg::pipe_ld_type   ld;

   hsv2rgb_pkg::sector_type    sec1, sec3, sec4;
   logic [FW-1:0]              fn1;
   logic [CW-1:0]              sat1, bri1, bri3, cp3, bri4, cp4;
   logic [NW-1:0]              nq3, nt3;
   logic [QW-1:0]              cq4, ct4;
   logic [CW-1:0]              cq_s, ct_s;

   logic [CW-1:0]              red_ff, red_in;
   logic [CW-1:0]              green_ff, green_in;
   logic [CW-1:0]              blue_ff, blue_in;

   // ready ripples back from the output; a stage moves if it is empty
   // or its successor moves
   always_comb begin
      rdy[NS] = rsp_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      ld = hsv2rgb_pkg::pipe_ld_type'(rdy[NS-1:0]);
      vld_in = {vld_ff[NS-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = vld_ff[NS-1];

   hsv2rgb_sector u_sector (
      .clock      (clock),
      .ld         (ld.s1),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .sec_ff     (sec1),
      .fn_ff      (fn1),
      .sat_ff     (sat1),
      .bri_ff     (bri1)
   );

   hsv2rgb_mult u_mult (
      .clock   (clock),
      .ld      (ld),
      .sec     (sec1),
      .fn      (fn1),
      .sat     (sat1),
      .bri     (bri1),
      .sec3_ff (sec3),
      .bri3_ff (bri3),
      .cp3_ff  (cp3),
      .nq3_ff  (nq3),
      .nt3_ff  (nt3)
   );

   hsv2rgb_div u_div (
      .clock  (clock),
      .ld     (ld.s4),
      .sec    (sec3),
      .bri    (bri3),
      .cp     (cp3),
      .nq     (nq3),
      .nt     (nt3),
      .sec_ff (sec4),
      .bri_ff (bri4),
      .cp_ff  (cp4),
      .cq_ff  (cq4),
      .ct_ff  (ct4)
   );

   // saturate q and t to 255, then order the channels by sector
   always_comb begin
      cq_s = cq4[QW-1:CW] != '0 ? CW'(hsv2rgb_pkg::UNIT) : cq4[CW-1:0];
      ct_s = ct4[QW-1:CW] != '0 ? CW'(hsv2rgb_pkg::UNIT) : ct4[CW-1:0];
      case (sec4)
         hsv2rgb_pkg::SEC_R_Y: begin
            red_in = bri4;  green_in = ct_s;  blue_in = cp4;
         end
         hsv2rgb_pkg::SEC_Y_G: begin
            red_in = cq_s;  green_in = bri4;  blue_in = cp4;
         end
         hsv2rgb_pkg::SEC_G_C: begin
            red_in = cp4;   green_in = bri4;  blue_in = ct_s;
         end
         hsv2rgb_pkg::SEC_C_B: begin
            red_in = cp4;   green_in = cq_s;  blue_in = bri4;
         end
         hsv2rgb_pkg::SEC_B_M: begin
            red_in = ct_s;  green_in = cp4;   blue_in = bri4;
         end
         default: begin
            red_in = bri4;  green_in = cp4;   blue_in = cq_s;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ld.s5) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

`default_nettype wire
